### rtl/arp_address_cache_assert.svh
// ----------------------------------------------------------------------------
// arp address cache assertion macros
// implication checks sampled on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ARP_ADDRESS_CACHE_ASSERT_SVH
`define ARP_ADDRESS_CACHE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ARPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arpc same-cycle check failed");
// next-cycle implication
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arpc next-cycle check failed");
`else
`define ARPC_ASSERT_NOW(lbl, ante, cons)
`define ARPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// sizes, codes and shared structs of the arp address cache
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

    localparam int OP_W  = 3;
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int ST_W  = 3;
    localparam int EC_W  = 5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CACHE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);

    // operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_ACCEPT  = 3'd3;
    localparam logic [OP_W-1:0] OP_PENDING = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_MISS   = 3'd1;
    localparam logic [ST_W-1:0] ST_ZERO   = 3'd2;
    localparam logic [ST_W-1:0] ST_REJECT = 3'd3;
    localparam logic [ST_W-1:0] ST_EVICT  = 3'd4;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IP_W-1:0]  wr_ip;
        logic [MAC_W-1:0] wr_mac;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_mem_rsp;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [MAC_W-1:0] mac;
        logic [EC_W-1:0]  count;
    } t_result;

endpackage

### rtl/arpc_req_if.sv
// ----------------------------------------------------------------------------
// arpc_req_if
// request channel: operation code, ipv4 address and mac address
// ----------------------------------------------------------------------------
interface arpc_req_if
    import arpc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;

    modport source (output valid, output opcode, output ip_addr, output mac_addr,
                    input ready);
    modport sink   (input valid, input opcode, input ip_addr, input mac_addr,
                    output ready);
endinterface

### rtl/arpc_rsp_if.sv
// ----------------------------------------------------------------------------
// arpc_rsp_if
// response channel: status, found mac address and entry count
// ----------------------------------------------------------------------------
interface arpc_rsp_if
    import arpc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [MAC_W-1:0] mac_out;
    logic [EC_W-1:0]  entry_count;

    modport source (output valid, output status, output mac_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input mac_out, input entry_count,
                    output ready);
endinterface

### rtl/arpc_table.sv
// ----------------------------------------------------------------------------
// arpc_table
// entry storage: one write and one registered read per cycle
// ----------------------------------------------------------------------------
module arpc_table
    import arpc_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_mem,
    output t_mem_rsp o_mem
);

    logic [IP_W-1:0]  r_ip_mem  [CACHE_ENTRIES];
    logic [MAC_W-1:0] r_mac_mem [CACHE_ENTRIES];
    logic [IP_W-1:0]  r_rd_ip;
    logic [MAC_W-1:0] r_rd_mac;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_ip_mem[i_mem.wr_addr]  <= i_mem.wr_ip;
            r_mac_mem[i_mem.wr_addr] <= i_mem.wr_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ip  <= r_ip_mem[i_mem.rd_addr];
        r_rd_mac <= r_mac_mem[i_mem.rd_addr];
    end

    assign o_mem.ip  = r_rd_ip;
    assign o_mem.mac = r_rd_mac;

endmodule

### rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// sequencer: walks the table with one address comparator, shifts on eviction
// ----------------------------------------------------------------------------
`include "arp_address_cache_assert.svh"

module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [OP_W-1:0]  i_req_op,
    input  logic [IP_W-1:0]  i_req_ip,
    input  logic [MAC_W-1:0] i_req_mac,
    output logic             o_req_ready,
    output t_mem_req         o_mem,
    input  t_mem_rsp         i_mem,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_take
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [OP_W-1:0]  r_op, n_op;
    logic [IP_W-1:0]  r_ip, n_ip;
    logic [MAC_W-1:0] r_mac, n_mac;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IP_W-1:0]  r_pending, n_pending;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_pend, n_pend;
    logic [ST_W-1:0]  r_status, n_status;
    logic [MAC_W-1:0] r_res_mac, n_res_mac;

    logic match;
    logic last;

    // compare the entry read last cycle
    assign match = r_pend && (i_mem.ip == r_ip);
    assign last  = (r_count == '0) ||
                   (r_pend && (r_cmp_idx == IDX_W'(r_count - CNT_W'(1))));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_ip      = r_ip;
        n_mac     = r_mac;
        n_count   = r_count;
        n_pending = r_pending;
        n_idx     = r_idx;
        n_cmp_idx = r_cmp_idx;
        n_pend    = 1'b0;
        n_status  = r_status;
        n_res_mac = r_res_mac;

        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = r_cmp_idx;
        o_mem.wr_ip   = r_ip;
        o_mem.wr_mac  = r_mac;
        o_mem.rd_addr = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op      = i_req_op;
                    n_ip      = i_req_ip;
                    n_mac     = i_req_mac;
                    n_idx     = '0;
                    n_status  = ST_OK;
                    n_res_mac = '0;
                    n_state   = S_DONE;
                    case (i_req_op)
                        OP_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        OP_ADD, OP_UPDATE: begin
                            if (i_req_ip == '0) begin
                                n_status = ST_ZERO;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_ACCEPT: begin
                            if ((r_pending == '0) || (i_req_ip != r_pending)) begin
                                n_status = ST_REJECT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_PENDING: begin
                            n_pending = i_req_ip;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    if (r_op == OP_LOOKUP) begin
                        n_res_mac = i_mem.mac;
                    end else begin
                        // refresh the mac of the matching entry
                        o_mem.wr_en = 1'b1;
                        if (r_op == OP_ACCEPT) begin
                            n_pending = '0;
                        end
                    end
                    n_state = S_DONE;
                end else if (last) begin
                    if ((r_op == OP_LOOKUP) || (r_op == OP_UPDATE)) begin
                        n_status = ST_MISS;
                        n_state  = S_DONE;
                    end else begin
                        if (r_op == OP_ACCEPT) begin
                            n_pending = '0;
                        end
                        if (r_count < FULL_CNT) begin
                            // append after the last filled entry
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_count[IDX_W-1:0];
                            n_count       = r_count + CNT_W'(1);
                            n_state       = S_DONE;
                        end else begin
                            n_idx   = CNT_W'(2);
                            n_state = S_SHIFT;
                        end
                    end
                end else begin
                    n_pend    = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    // move entry down by one, entry 0 stays pinned
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_cmp_idx - IDX_W'(1);
                    o_mem.wr_ip   = i_mem.ip;
                    o_mem.wr_mac  = i_mem.mac;
                end
                if (r_idx <= LAST_CNT) begin
                    n_pend    = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                end else if (!r_pend) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = LAST_IDX;
                    n_status      = ST_EVICT;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pending <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pending <= n_pending;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_ip      <= n_ip;
        r_mac     <= n_mac;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_status  <= n_status;
        r_res_mac <= n_res_mac;
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.mac    = r_res_mac;
    assign o_res.count  = EC_W'(r_count);

    `ARPC_ASSERT_NOW(a_count_range, 1'b1, r_count <= FULL_CNT)
    `ARPC_ASSERT_NOW(a_shift_full, r_state == S_SHIFT, r_count == FULL_CNT)
    `ARPC_ASSERT_NOW(a_wr_state, o_mem.wr_en, (r_state == S_SCAN) || (r_state == S_SHIFT))
    `ARPC_ASSERT_NEXT(a_busy_after_accept, i_req_valid && o_req_ready, r_state != S_IDLE)
    `ARPC_ASSERT_NOW(a_evict_full, o_res_valid && (r_status == ST_EVICT), r_count == FULL_CNT)

endmodule

### rtl/arp_address_cache.sv
// ----------------------------------------------------------------------------
// arp_address_cache
// table of ipv4 to mac address pairs with lookup, add, update and eviction
// ----------------------------------------------------------------------------
// usage:
// - i_req carries one request: opcode, ip_addr, mac_addr; it is taken at a
//   clock edge with valid and ready high, and o_rsp returns exactly one
//   response per request: status, mac_out, entry_count
// - one request is worked at a time; ready stays low until its response has
//   moved into the output register
// - one address comparator walks the filled entries from index 0, one entry
//   per cycle behind a registered table read, until a match or the last
//   filled entry decides the answer
// - an add or accepted reply to a full table also shifts entries 2 .. N-1
//   down by one through the single write port, new pair last (N = 16 here)
// - set pending, clear and zero-address or rejected requests skip the table walk
// - the response waits in the output register while the receiver stalls;
//   a new request may be taken meanwhile, and its result is held back until
//   the output register is free
// - reset empties the table and drops the pending address; the entry
//   storage itself is not cleared, entries are only read below the count
// ----------------------------------------------------------------------------
module arp_address_cache
    import arpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    arpc_req_if.sink          i_req,
    arpc_rsp_if.source        o_rsp
);

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    t_result  res;
    logic     res_valid;
    logic     res_take;

    logic     r_out_vld;
    t_result  r_out;

    // sequencer with the shared comparator
    arpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.opcode),
        .i_req_ip    (i_req.ip_addr),
        .i_req_mac   (i_req.mac_addr),
        .o_req_ready (i_req.ready),
        .o_mem       (mem_req),
        .i_mem       (mem_rsp),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // entry storage
    arpc_table u_table (
        .i_clk (i_clk),
        .i_mem (mem_req),
        .o_mem (mem_rsp)
    );

    // output register: free when empty or drained this cycle
    assign res_take = res_valid && (!r_out_vld || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.mac_out     = r_out.mac;
    assign o_rsp.entry_count = r_out.count;

endmodule

### dv/tb_arp_address_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arp_address_cache
// self-checking bench for the arp address cache: a shadow table predicts
// every response, requests go out in random bursts, responses are taken
// under a changing stall pattern and compared field by field in order
// ----------------------------------------------------------------------------
module tb_arp_address_cache;
    import arpc_pkg::*;

    // unused opcodes, the block treats them as no-ops
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_REQS  = 400;
    localparam int POOL_SIZE    = 24;
    // margin for the worst request, an add into a full table, with one response in flight
    localparam int DRAIN_CYCLES = 2 * CACHE_ENTRIES + 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;

    arpc_req_if req_if ();
    arpc_rsp_if rsp_if ();

    arp_address_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the table, the count and the pending address
    logic [IP_W-1:0]  shadow_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0] shadow_mac [CACHE_ENTRIES];
    int               shadow_used;
    logic [IP_W-1:0]  shadow_pending;

    // responses predicted at request acceptance, oldest first
    t_result awaited_rsp [$];

    logic [IP_W-1:0] ip_pool [POOL_SIZE];

    int mismatches;
    int requests_sent;
    int responses_checked;
    int lookup_hits;
    int evictions;
    int burst_left;
    int hold_off_left;
    int cycle_cnt;

    // ------------------------------------------------------------------------
    // clock and cycle watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses still awaited",
                     cycle_cnt, awaited_rsp.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // shadow table
    // ------------------------------------------------------------------------
    // first filled entry holding ip, -1 on a miss
    function automatic int find_shadow(input logic [IP_W-1:0] ip);
        int k;
        for (k = 0; k < shadow_used; k++) begin
            if (shadow_ip[k] == ip) return k;
        end
        return -1;
    endfunction

    // refresh or append; a full table keeps the gateway in entry 0
    // and shifts the rest down so the new pair lands last
    function automatic logic [ST_W-1:0] insert_shadow(input logic [IP_W-1:0]  ip,
                                                      input logic [MAC_W-1:0] mac);
        int hit;
        int k;
        hit = find_shadow(ip);
        if (hit >= 0) begin
            shadow_mac[hit] = mac;
            return ST_OK;
        end
        if (shadow_used < CACHE_ENTRIES) begin
            shadow_ip[shadow_used]  = ip;
            shadow_mac[shadow_used] = mac;
            shadow_used++;
            return ST_OK;
        end
        for (k = 1; k < CACHE_ENTRIES - 1; k++) begin
            shadow_ip[k]  = shadow_ip[k + 1];
            shadow_mac[k] = shadow_mac[k + 1];
        end
        shadow_ip[CACHE_ENTRIES - 1]  = ip;
        shadow_mac[CACHE_ENTRIES - 1] = mac;
        return ST_EVICT;
    endfunction

    // applies one request to the shadow state, returns its response
    function automatic t_result resolve_request(input logic [OP_W-1:0]  op,
                                                input logic [IP_W-1:0]  ip,
                                                input logic [MAC_W-1:0] mac);
        t_result rsp;
        int      hit;
        rsp.status = ST_OK;
        rsp.mac    = '0;
        case (op)
            OP_LOOKUP: begin
                hit = find_shadow(ip);
                if (hit >= 0) begin
                    rsp.mac = shadow_mac[hit];
                    lookup_hits++;
                end else begin
                    rsp.status = ST_MISS;
                end
            end
            OP_ADD: begin
                if (ip == '0) rsp.status = ST_ZERO;
                else          rsp.status = insert_shadow(ip, mac);
            end
            OP_UPDATE: begin
                if (ip == '0) begin
                    rsp.status = ST_ZERO;
                end else begin
                    hit = find_shadow(ip);
                    if (hit >= 0) shadow_mac[hit] = mac;
                    else          rsp.status = ST_MISS;
                end
            end
            OP_ACCEPT: begin
                // only a reply to the address we asked for gets in
                if (shadow_pending == '0 || ip != shadow_pending) begin
                    rsp.status = ST_REJECT;
                end else begin
                    rsp.status     = insert_shadow(ip, mac);
                    shadow_pending = '0;
                end
            end
            OP_PENDING: shadow_pending = ip;
            OP_CLEAR:   shadow_used = 0;
            default: ;
        endcase
        rsp.count = EC_W'(shadow_used);
        if (rsp.status == ST_EVICT) evictions++;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // drives one request and waits for its handshake; bursts of random
    // length with random idle gaps between them
    task automatic send_request(input logic [OP_W-1:0]  op,
                                input logic [IP_W-1:0]  ip,
                                input logic [MAC_W-1:0] mac);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.ip_addr  <= ip;
        req_if.mac_addr <= mac;
        do @(posedge i_clk); while (!req_if.ready);
        awaited_rsp.push_back(resolve_request(op, ip, mac));
        requests_sent++;
    endtask

    // drop the request line and wait for every response to come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IP_W-1:0] pool_ip();
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // response side: checker plus stall pattern
    // ------------------------------------------------------------------------
    task automatic check_response();
        t_result want;
        if (awaited_rsp.size() == 0) begin
            $error("unexpected response: status %0d, mac_out %h, entry_count %0d",
                   rsp_if.status, rsp_if.mac_out, rsp_if.entry_count);
            mismatches++;
        end else begin
            want = awaited_rsp.pop_front();
            responses_checked++;
            if (rsp_if.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                mismatches++;
            end
            if (rsp_if.mac_out !== want.mac) begin
                $error("mac_out: expected %h, actual %h", want.mac, rsp_if.mac_out);
                mismatches++;
            end
            if (rsp_if.entry_count !== want.count) begin
                $error("entry_count: expected %0d, actual %0d",
                       want.count, rsp_if.entry_count);
                mismatches++;
            end
        end
    endtask

    // values read right after the edge are the ones the edge sampled
    initial begin : rsp_side
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) check_response();
            if (hold_off_left > 0) begin
                // long hold-off asked by the backpressure test
                hold_off_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // misses, zero addresses, field extremes, pending gating, reserved ops
    task automatic test_special_cases();
        send_request(OP_LOOKUP,  32'h0000_0000, rand_mac());       // empty table miss
        send_request(OP_ADD,     32'h0000_0000, {MAC_W{1'b1}});    // zero address ignored
        send_request(OP_UPDATE,  32'h0000_0000, {MAC_W{1'b1}});
        send_request(OP_UPDATE,  32'h0000_0001, rand_mac());       // update with no match
        send_request(OP_ACCEPT,  32'h0A00_0001, rand_mac());       // nothing pending
        send_request(OP_ADD,     32'hFFFF_FFFF, {MAC_W{1'b1}});
        send_request(OP_ADD,     32'h0000_0001, {MAC_W{1'b0}});
        send_request(OP_LOOKUP,  32'hFFFF_FFFF, '0);
        send_request(OP_UPDATE,  32'h0000_0001, 48'hAAAA_5555_AAAA);
        send_request(OP_LOOKUP,  32'h0000_0001, '0);
        send_request(OP_LOOKUP,  32'h0000_0000, '0);               // zero never matches
        send_request(OP_PENDING, 32'h0A00_0001, '0);
        send_request(OP_ACCEPT,  32'h0A00_0002, rand_mac());       // wrong address
        send_request(OP_ACCEPT,  32'h0A00_0001, 48'h5555_AAAA_5555);
        send_request(OP_ACCEPT,  32'h0A00_0001, rand_mac());       // pending already used
        send_request(OP_PENDING, 32'h0A00_0003, '0);
        send_request(OP_PENDING, 32'h0000_0000, '0);               // cancel
        send_request(OP_ACCEPT,  32'h0000_0000, rand_mac());
        send_request(OP_RSVD6,   32'hFFFF_FFFF, {MAC_W{1'b1}});
        send_request(OP_RSVD7,   32'h0A00_0001, rand_mac());
        send_request(OP_PENDING, 32'h0A00_0005, '0);
        send_request(OP_CLEAR,   32'h0A00_0001, rand_mac());       // pending survives clear
        send_request(OP_LOOKUP,  32'hFFFF_FFFF, '0);
        send_request(OP_ACCEPT,  32'h0A00_0005, rand_mac());
        send_request(OP_LOOKUP,  32'h0A00_0005, '0);
    endtask

    // fill to capacity, then evict with the gateway pinned in entry 0
    task automatic test_fill_and_evict();
        int k;
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_ADD, 32'hC0A8_0001, 48'h0000_0000_0001);   // gateway
        for (k = 1; k < CACHE_ENTRIES; k++)
            send_request(OP_ADD, 32'h0A01_0000 + k, rand_mac());
        send_request(OP_ADD, 32'h0A01_0100, rand_mac());           // evicts entry 1
        send_request(OP_ADD, 32'h0A01_0101, rand_mac());
        send_request(OP_ADD, 32'h0A01_0003, rand_mac());           // refresh, no eviction
        send_request(OP_LOOKUP, 32'hC0A8_0001, '0);
        send_request(OP_LOOKUP, 32'h0A01_0001, '0);                // shifted out
        send_request(OP_LOOKUP, 32'h0A01_0101, '0);                // last slot
        send_request(OP_PENDING, 32'h0A01_0200, '0);
        send_request(OP_ACCEPT, 32'h0A01_0200, rand_mac());        // accept into full table
        send_request(OP_LOOKUP, 32'h0A01_0200, '0);
    endtask

    // receiver holds off long enough for the block to stall its input,
    // then the sender pauses until everything has come back
    task automatic test_backpressure();
        int k;
        hold_off_left = 300;
        for (k = 0; k < 10; k++) begin
            if (k[0]) send_request(OP_LOOKUP, pool_ip(), '0);
            else      send_request(OP_ADD, pool_ip(), rand_mac());
        end
        wait_drained();
    endtask

    // mostly well-formed traffic on a small address pool so that hits,
    // refreshes and evictions are common; some noise and broken exchanges
    task automatic test_random_traffic();
        int               sent;
        int               pick;
        logic [IP_W-1:0]  ip;
        sent = 0;
        while (sent < RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            ip   = pool_ip();
            if (pick < 30) begin
                send_request(OP_LOOKUP, ip, rand_mac());
            end else if (pick < 52) begin
                send_request(OP_ADD, ip, rand_mac());
            end else if (pick < 55) begin
                send_request(OP_ADD, '0, rand_mac());
            end else if (pick < 65) begin
                if ($urandom_range(0, 9) == 0) ip = '0;
                send_request(OP_UPDATE, ip, rand_mac());
            end else if (pick < 80) begin
                // request then reply, sometimes from the wrong address
                send_request(OP_PENDING, ip, rand_mac());
                if ($urandom_range(0, 4) == 0) ip = pool_ip();
                send_request(OP_ACCEPT, ip, rand_mac());
                sent++;
            end else if (pick < 84) begin
                send_request(OP_ACCEPT, ($urandom_range(0, 1) == 0) ? '0 : ip, rand_mac());
            end else if (pick < 87) begin
                send_request(OP_PENDING, ($urandom_range(0, 1) == 0) ? '0 : $urandom, '0);
            end else if (pick < 89) begin
                send_request(OP_CLEAR, $urandom, rand_mac());
            end else if (pick < 92) begin
                send_request(($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7,
                             $urandom, rand_mac());
            end else begin
                send_request(OP_LOOKUP, $urandom, rand_mac());
            end
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : main
        int k;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.opcode   <= OP_LOOKUP;
        req_if.ip_addr  <= '0;
        req_if.mac_addr <= '0;
        cycle_cnt         = 0;
        mismatches        = 0;
        requests_sent     = 0;
        responses_checked = 0;
        lookup_hits       = 0;
        evictions         = 0;
        burst_left        = 0;
        hold_off_left     = 0;
        shadow_used       = 0;
        shadow_pending    = '0;
        for (k = 0; k < POOL_SIZE; k++) begin
            ip_pool[k] = $urandom;
            if (ip_pool[k] == '0) ip_pool[k] = 32'h0000_0001;
        end
        ip_pool[0] = 32'hFFFF_FFFF;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_fill_and_evict();
        test_backpressure();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_rsp.size() != 0) begin
            $error("%0d responses never arrived", awaited_rsp.size());
            mismatches++;
        end

        $display("covered %0d requests, %0d responses checked, %0d lookup hits, %0d evictions",
                 requests_sent, responses_checked, lookup_hits, evictions);
        $display("included every opcode, zero addresses, pending gating and long stalls");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_req_if.sv
rtl/arpc_rsp_if.sv
rtl/arpc_table.sv
rtl/arpc_ctrl.sv
rtl/arp_address_cache.sv
dv/tb_arp_address_cache.sv
